// ===== sv/csq_pkg.sv =====
// ============================================================================
// csq_pkg: shared types and constants for the cursor sequence store
// Operation and status codes, sequencer states and fixed field widths.
// ============================================================================
package csq_pkg;

  // Default sizing
  localparam int DepthDef     = 64;
  localparam int ValueBitsDef = 32;

  // Fixed field widths of the channels
  localparam int OpW    = 3;
  localparam int ValW   = 32;
  localparam int PosW   = 6;
  localparam int StatW  = 2;
  localparam int CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_START   = 3'd0,
    OP_ADVANCE = 3'd1,
    OP_INSERT  = 3'd2,
    OP_ATTACH  = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_CUR = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_RDPOS,
    S_FETCH,
    S_RESULT
  } state_e;

endpackage

// ===== sv/csq_if.sv =====
// ============================================================================
// csq_if: valid/ready channels of the cursor sequence store
// Request channel carries one operation, result channel one status beat.
// ============================================================================
interface csq_req_if;
  logic                        valid;
  logic                        ready;
  logic [csq_pkg::OpW-1:0]     operation;
  logic [csq_pkg::ValW-1:0]    value;
  logic [csq_pkg::PosW-1:0]    position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface csq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [csq_pkg::StatW-1:0]   status;
  logic [csq_pkg::CountW-1:0]  item_count;
  logic                        has_current;
  logic [csq_pkg::ValW-1:0]    current_value;
  logic [csq_pkg::ValW-1:0]    read_value;

  modport source (output valid, output status, output item_count, output has_current,
                  output current_value, output read_value, input ready);
  modport sink   (input valid, input status, input item_count, input has_current,
                  input current_value, input read_value, output ready);
endinterface

// ===== sv/cursor_sequence_store.sv =====
// ============================================================================
// cursor_sequence_store: ordered value store with a cursor
// Entries live in one synchronous RAM; insert and remove walk the RAM to
// shift later entries by one place, then the current entry is read back.
// ============================================================================
// Request flow: start, advance, spare codes, refusals and removing the
//   entry at the end go straight to the current-entry fetch; a read first
//   reads its position; insert/attach and remove moving n > 0 entries walk
//   them (one per cycle, n up to DEPTH - 1); every insert/attach then writes
//   its value. Only one request is in flight at a time.
// Reset: count and cursor clear at once; RAM contents are not cleared.
module cursor_sequence_store #(
  parameter int DEPTH      = csq_pkg::DepthDef,
  parameter int VALUE_BITS = csq_pkg::ValueBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csq_req_if.sink    in_i,
  csq_rsp_if.source  out_o
);
  import csq_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > PosW) ? CNT_W : PosW;
  localparam int MEM_W = (VALUE_BITS < ValW) ? VALUE_BITS : ValW;

  // Storage
  logic [MEM_W-1:0] entries_q [DEPTH];
  logic [MEM_W-1:0] rdata_q;

  // Architectural state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, cursor_q;

  // Per-request context
  status_e          status_q;
  logic             put_q, rdpos_q, dir_up_q, has_cur_q;
  logic [AW-1:0]    put_addr_q, pos_q, ptr_q, last_q, wr_addr_q;
  logic [MEM_W-1:0] val_q, rdv_q;
  logic             wr_pend_q;

  // Output register
  logic             out_valid_q;
  status_e          out_status_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_has_cur_q;
  logic [MEM_W-1:0] out_cur_q, out_rd_q;

  // Decode results
  logic             in_ready, accept, out_free;
  logic             cur, full;
  status_e          dec_status;
  logic [CNT_W-1:0] dec_count, dec_cursor;
  logic             dec_shift, dec_put, dec_rdpos, dec_up;
  logic [AW-1:0]    dec_ptr, dec_last, dec_put_addr;

  // RAM port controls
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [MEM_W-1:0] mem_wdata;
  logic             load_out;

  assign cur      = cursor_q < count_q;
  assign full     = count_q == CNT_W'(DEPTH);
  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_ready;

  // Request decode: new count/cursor and the RAM walk to run
  always_comb begin
    logic [CNT_W-1:0] p;
    p            = '0;
    dec_status   = ST_OK;
    dec_count    = count_q;
    dec_cursor   = cursor_q;
    dec_shift    = 1'b0;
    dec_put      = 1'b0;
    dec_rdpos    = 1'b0;
    dec_up       = 1'b0;
    dec_ptr      = '0;
    dec_last     = '0;
    dec_put_addr = '0;
    case (op_e'(in_i.operation))
      OP_START: begin
        dec_cursor = '0;
      end
      OP_ADVANCE: begin
        if (cur) dec_cursor = cursor_q + CNT_W'(1);
        else     dec_status = ST_NO_CUR;
      end
      OP_INSERT, OP_ATTACH: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          if (op_e'(in_i.operation) == OP_INSERT) p = cur ? cursor_q : '0;
          else                                    p = cur ? cursor_q + CNT_W'(1) : count_q;
          dec_cursor   = p;
          dec_count    = count_q + CNT_W'(1);
          dec_put      = 1'b1;
          dec_put_addr = AW'(p);
          dec_shift    = p != count_q;
          dec_ptr      = AW'(count_q - CNT_W'(1));
          dec_last     = AW'(p);
        end
      end
      OP_REMOVE: begin
        if (!cur) begin
          dec_status = ST_NO_CUR;
        end else begin
          dec_count = count_q - CNT_W'(1);
          dec_shift = (cursor_q + CNT_W'(1)) != count_q;
          dec_up    = 1'b1;
          dec_ptr   = AW'(cursor_q + CNT_W'(1));
          dec_last  = AW'(count_q - CNT_W'(1));
        end
      end
      OP_READ: begin
        if (CMP_W'(in_i.position) < CMP_W'(count_q)) dec_rdpos = 1'b1;
        else                                          dec_status = ST_RANGE;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (dec_shift)      state_d = S_SHIFT;
          else if (dec_put)   state_d = S_PUT;
          else if (dec_rdpos) state_d = S_RDPOS;
          else                state_d = S_FETCH;
        end
      end
      S_SHIFT:  if (ptr_q == last_q) state_d = S_DRAIN;
      S_DRAIN:  state_d = put_q ? S_PUT : S_FETCH;
      S_PUT:    state_d = S_FETCH;
      S_RDPOS:  state_d = S_FETCH;
      S_FETCH:  state_d = S_RESULT;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // State outputs: handshake and RAM port selection
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = rdata_q;
    load_out  = 1'b0;
    case (state_q)
      S_IDLE:  in_ready = 1'b1;
      S_SHIFT: mem_re = 1'b1;
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = put_addr_q;
        mem_wdata = val_q;
      end
      S_RDPOS: begin
        mem_re    = 1'b1;
        mem_raddr = pos_q;
      end
      S_FETCH: begin
        mem_re    = cur;
        mem_raddr = AW'(cursor_q);
      end
      S_RESULT: load_out = out_free;
      default: begin
      end
    endcase
    // trailing write of the shift walk
    if (wr_pend_q) mem_we = 1'b1;
  end

  // Entry RAM, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) entries_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= entries_q[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= state_q == S_SHIFT;
      if (accept) begin
        count_q  <= dec_count;
        cursor_q <= dec_cursor;
      end
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Request context and shift walk pointers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= dec_status;
      put_q      <= dec_put;
      put_addr_q <= dec_put_addr;
      rdpos_q    <= dec_rdpos;
      dir_up_q   <= dec_up;
      ptr_q      <= dec_ptr;
      last_q     <= dec_last;
      val_q      <= in_i.value[MEM_W-1:0];
      pos_q      <= AW'(in_i.position);
    end
    if (state_q == S_SHIFT) begin
      wr_addr_q <= dir_up_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
      ptr_q     <= dir_up_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
    end
    if (state_q == S_FETCH) begin
      rdv_q     <= rdpos_q ? rdata_q : '0;
      has_cur_q <= cur;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q  <= status_q;
      out_count_q   <= count_q;
      out_has_cur_q <= has_cur_q;
      out_cur_q     <= has_cur_q ? rdata_q : '0;
      out_rd_q      <= rdv_q;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.item_count    = CountW'(out_count_q);
  assign out_o.has_current   = out_has_cur_q;
  assign out_o.current_value = ValW'(out_cur_q);
  assign out_o.read_value    = ValW'(out_rd_q);

endmodule

// ===== sv/csq_checker.sv =====
// ============================================================================
// csq_checker: port-level checks for the cursor sequence store
// Watches the result channel for held beats and consistent fields.
// ============================================================================
module csq_checker #(
  parameter int DEPTH = csq_pkg::DepthDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [csq_pkg::StatW-1:0]   status_i,
  input logic [csq_pkg::CountW-1:0]  item_count_i,
  input logic                        has_current_i,
  input logic [csq_pkg::ValW-1:0]    current_value_i,
  input logic [csq_pkg::ValW-1:0]    read_value_i
);
  import csq_pkg::*;

  // Stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(item_count_i) && $stable(current_value_i) && $stable(read_value_i))
    else $error("result beat changed while stalled");

  // No current entry means a zero current value
  a_no_cur_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_current_i |-> current_value_i == '0)
    else $error("current value without current entry");

  // Read data only on a successful request
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> read_value_i == '0)
    else $error("read value on refused request");

  // Full refusal only when the store holds DEPTH entries
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FULL |-> item_count_i == CountW'(DEPTH))
    else $error("full status with short count");

endmodule

bind cursor_sequence_store csq_checker #(.DEPTH(DEPTH)) u_csq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .item_count_i    (out_o.item_count),
  .has_current_i   (out_o.has_current),
  .current_value_i (out_o.current_value),
  .read_value_i    (out_o.read_value)
);
